[hdl/msfe_pkg.sv]
`default_nettype none

package msfe_pkg;

    // Frame layout and fixed bytes
    localparam int unsigned FRAME_LEN = 9;
    localparam logic [7:0] SOF_BYTE = 8'h1b;
    localparam logic [7:0] CODE_MASK = 8'h10;
    localparam logic [7:0] EOF_BYTE = 8'h05;
    localparam logic [15:0] CRC_INIT = 16'hffff;
    localparam logic [15:0] CRC_POLY = 16'ha001;
    localparam logic [15:0] MAG_MAX = 16'hffff;

    // Send positions within a frame
    localparam logic [3:0] POS_SOF = 4'd0;
    localparam logic [3:0] POS_CODE = 4'd1;
    localparam logic [3:0] POS_LEFT_HI = 4'd2;
    localparam logic [3:0] POS_LEFT_LO = 4'd3;
    localparam logic [3:0] POS_RIGHT_HI = 4'd4;
    localparam logic [3:0] POS_RIGHT_LO = 4'd5;
    localparam logic [3:0] POS_CRC_HI = 4'd6;
    localparam logic [3:0] POS_CRC_LO = 4'd7;
    localparam logic [3:0] POS_EOF = 4'd8;

    // Register map, also the direction index of each code
    typedef enum logic [1:0] {
        REG_FWD_FWD   = 2'd0,
        REG_FWD_BACK  = 2'd1,
        REG_BACK_FWD  = 2'd2,
        REG_BACK_BACK = 2'd3
    } reg_idx_t;

    typedef logic [7:0] code_arr_t [4];

    // One command as handed from the input stage to the serialiser
    typedef struct packed {
        logic [7:0]  code_byte;
        logic [15:0] left_mag;
        logic [15:0] right_mag;
        logic        changed;
    } frame_t;

    // Saturating magnitude of a 17-bit two's complement speed
    function automatic logic [15:0] speed_mag(input logic [16:0] v);
        logic [16:0] mag;
        mag = v[16] ? (~v + 17'd1) : v;
        return mag[16] ? MAG_MAX : mag[15:0];
    endfunction

    // Fold one byte into a CRC-16/MODBUS remainder
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

[hdl/msfe_cfg.sv]
`default_nettype none

module msfe_cfg
    import msfe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output code_arr_t        codes
);

    code_arr_t codes_reg;
    logic [1:0] sel;

    assign sel = paddr[3:2];
    assign pready = 1'b1;
    assign codes = codes_reg;

    // Write the addressed direction code
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg[REG_FWD_FWD]   <= 8'd0;
            codes_reg[REG_FWD_BACK]  <= 8'd1;
            codes_reg[REG_BACK_FWD]  <= 8'd2;
            codes_reg[REG_BACK_BACK] <= 8'd3;
        end else if (psel && penable && pwrite && pready) begin
            codes_reg[sel] <= pwdata[7:0];
        end
    end

    // Read back
    assign prdata = {24'd0, codes_reg[sel]};

endmodule

`default_nettype wire

[hdl/msfe_build.sv]
`default_nettype none

module msfe_build
    import msfe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire code_arr_t   codes,
    input  wire logic        take,
    output frame_t           frame,
    output logic             frame_valid
);

    frame_t     frame_reg;
    logic       valid_reg;
    logic [1:0] dir_reg;
    logic [1:0] dir;
    logic [16:0] left_speed;
    logic [16:0] right_speed;
    logic       accept;

    assign left_speed  = s_tdata[16:0];
    assign right_speed = s_tdata[33:17];
    assign dir = {left_speed[16], right_speed[16]};

    // Free whenever empty or the serialiser takes the held command
    assign s_tready = !valid_reg || take;
    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            dir_reg   <= REG_FWD_FWD;
        end else if (accept) begin
            valid_reg <= 1'b1;
            dir_reg   <= dir;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    // Capture the command fields of an accepted beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            frame_reg.code_byte <= codes[dir] ^ CODE_MASK;
            frame_reg.left_mag  <= speed_mag(left_speed);
            frame_reg.right_mag <= speed_mag(right_speed);
            frame_reg.changed   <= (dir != dir_reg);
        end
    end

    assign frame = frame_reg;
    assign frame_valid = valid_reg;

endmodule

`default_nettype wire

[hdl/msfe_ser.sv]
`default_nettype none

module msfe_ser
    import msfe_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire frame_t     frame,
    input  wire logic       frame_valid,
    output logic            take,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);

    frame_t      hold_reg;
    logic        busy_reg;
    logic [3:0]  pos_reg;
    logic [15:0] crc_reg;
    logic [7:0]  cur_byte;
    logic        beat;
    logic        at_last;
    logic        in_crc_span;

    assign beat    = busy_reg && m_tready;
    assign at_last = (pos_reg == POS_EOF);
    assign take    = frame_valid && (!busy_reg || (beat && at_last));
    assign in_crc_span = (pos_reg >= POS_CODE) && (pos_reg <= POS_RIGHT_LO);

    // Select the byte at the current send position
    always_comb begin
        unique case (pos_reg)
            POS_SOF:      cur_byte = SOF_BYTE;
            POS_CODE:     cur_byte = hold_reg.code_byte;
            POS_LEFT_HI:  cur_byte = hold_reg.left_mag[15:8];
            POS_LEFT_LO:  cur_byte = hold_reg.left_mag[7:0];
            POS_RIGHT_HI: cur_byte = hold_reg.right_mag[15:8];
            POS_RIGHT_LO: cur_byte = hold_reg.right_mag[7:0];
            POS_CRC_HI:   cur_byte = crc_reg[15:8];
            POS_CRC_LO:   cur_byte = crc_reg[7:0];
            POS_EOF:      cur_byte = EOF_BYTE;
            default:      cur_byte = 8'h00;
        endcase
    end

    // Advance through the frame, one byte per beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= POS_SOF;
        end else if (take) begin
            busy_reg <= 1'b1;
            pos_reg  <= POS_SOF;
        end else if (beat) begin
            if (at_last) begin
                busy_reg <= 1'b0;
                pos_reg  <= POS_SOF;
            end else begin
                pos_reg <= pos_reg + 4'd1;
            end
        end
    end

    // Hold the command and fold the CRC as bytes one to five go out
    always_ff @(posedge aclk) begin
        if (take) begin
            hold_reg <= frame;
            crc_reg  <= CRC_INIT;
        end else if (beat && in_crc_span) begin
            crc_reg <= crc_byte(crc_reg, cur_byte);
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = cur_byte;
    assign m_tlast  = at_last;
    assign m_tuser  = hold_reg.changed;

endmodule

`default_nettype wire

[hdl/motor_speed_frame_encoder.sv]
// The input beat is registered in the build stage and then taken into the serialiser, which
// presents the first frame byte once it has taken the command, when the serialiser is idle.
// Output: one frame byte per output beat from the serialiser.
// A following command is taken while the current frame is still going out.
// Reset (aresetn low, synchronous): direction codes return to 0..3, the stored
// direction to both forward, and both stages empty.
`default_nettype none

module motor_speed_frame_encoder
    import msfe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Speed input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [16:0] left_speed, [33:17] right_speed, zero pad
    // Frame output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [7:0] frame_byte
    output logic             m_tlast,
    output logic             m_tuser    // [0] direction_changed
);

    code_arr_t codes;
    frame_t    frame;
    logic      frame_valid;
    logic      take;

    msfe_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .codes   (codes)
    );

    msfe_build u_build (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .codes       (codes),
        .take        (take),
        .frame       (frame),
        .frame_valid (frame_valid)
    );

    msfe_ser u_ser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame       (frame),
        .frame_valid (frame_valid),
        .take        (take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire
